// File: rtl/taylor_sin_cos_exp_unit_top_macros.svh
// Assertion macros shared by the series unit
`ifndef TAYLOR_SIN_COS_EXP_UNIT_TOP_MACROS_SVH
`define TAYLOR_SIN_COS_EXP_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define TSCE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tsce_pkg.sv
// Shared types and constants for the sin/cos/exp series unit
package tsce_pkg;

   localparam int X_W       = 32;             // argument width
   localparam int RES_W     = 48;             // result width
   localparam int MAG_W     = 63;             // term magnitude, up to 2^62
   localparam int HALF_W    = 32;             // multiplier operand width
   localparam int PROD_W    = 96;             // term magnitude times argument magnitude
   localparam int WIDE_W    = 128;            // product padded for the scale step
   localparam int QUO_W     = 64;             // scaled product before saturation
   localparam int DIG_W     = 4;              // quotient bits per divider step
   localparam int DIV_W     = 64;             // divider dividend register
   localparam int DIV_STEPS = DIV_W / DIG_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [QUO_W-1:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

   localparam logic [1:0] FUNC_SIN  = 2'd0;
   localparam logic [1:0] FUNC_COS  = 2'd1;
   localparam logic [1:0] FUNC_EXP  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_SUM,
      ST_SCALE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic mul_en;    // register a new partial product
      logic acc_load;  // accumulator takes the low partial product
      logic acc_add;   // accumulator adds the high partial product
   } mul_ctrl_type;

endpackage

// File: rtl/tsce_mul_acc.sv
// Shared 32x32 multiplier with a two-pass product accumulator
module tsce_mul_acc (
   input  logic                         clock,
   input  tsce_pkg::mul_ctrl_type       ctrl,
   input  logic [tsce_pkg::HALF_W-1:0]  mul_a,
   input  logic [tsce_pkg::HALF_W-1:0]  mul_b,
   output logic [tsce_pkg::PROD_W-1:0]  acc
);
   import tsce_pkg::*;

   logic [2*HALF_W-1:0] prod_ff;
   logic [2*HALF_W-1:0] prod_in;
   logic [PROD_W-1:0]   acc_ff;

   assign prod_in = (2*HALF_W)'(mul_a) * (2*HALF_W)'(mul_b);

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_load) begin
         acc_ff <= PROD_W'(prod_ff);
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + {prod_ff, {HALF_W{1'b0}}};
      end
   end

   assign acc = acc_ff;

endmodule

// File: rtl/tsce_div_unit.sv
// Radix-16 iterative divider of a term magnitude by a small step index
module tsce_div_unit #(
   parameter int N_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tsce_pkg::MAG_W-1:0]  dividend,
   input  logic [N_W-1:0]              divisor,
   output logic                        done,
   output logic [tsce_pkg::MAG_W-1:0]  quotient
);
   import tsce_pkg::*;

   localparam int PART_W = N_W + DIG_W;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic [DIV_W-1:0]  dq_ff;
   logic [N_W-1:0]    rem_ff;
   logic [N_W-1:0]    rem_in;
   logic [N_W-1:0]    dsr_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [PART_W-1:0] partial;
   logic [DIG_W-1:0]  digit;

   assign partial = {rem_ff, dq_ff[DIV_W-1 -: DIG_W]};

   // largest digit whose multiple of the divisor still fits the partial remainder
   always_comb begin
      digit = '0;
      for (int k = 1; k < 2**DIG_W; k++) begin
         if (PART_W'(k) * PART_W'(dsr_ff) <= partial) begin
            digit = DIG_W'(k);
         end
      end
      rem_in = N_W'(partial - PART_W'(digit) * PART_W'(dsr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == LAST_STEP) && !start;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= STEP_W'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_STEP) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= DIV_W'(dividend);
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         dq_ff  <= {dq_ff[DIV_W-DIG_W-1:0], digit};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff[MAG_W-1:0];

endmodule

// File: rtl/taylor_sin_cos_exp_unit_top.sv
// Top level of the sin/cos/exp Taylor series unit.
// One item at a time; busy stays high from the accept until the result strobe.
// Each term after the first passes the shared multiplier (low, high, sum), a scale
// step, the radix-16 divider and an accumulate step. Last term index: sin 41, cos 40,
// exp 20 at the default TERM_COUNT; an unused func goes from idle to the strobe.
// Next item is accepted the cycle after the strobe. Synchronous reset returns to idle.
`include "taylor_sin_cos_exp_unit_top_macros.svh"

module taylor_sin_cos_exp_unit_top #(
   parameter int TERM_COUNT = 21,
   parameter int FRAC_BITS  = 28
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_func,
   input  logic signed [tsce_pkg::X_W-1:0]    req_x_value,
   output logic                               rsp_valid,
   output logic signed [tsce_pkg::RES_W-1:0]  rsp_result_value
);
   import tsce_pkg::*;

   localparam int N_W    = $clog2(2 * TERM_COUNT);
   localparam int SUMX_W = MAG_W + 2;
   localparam logic [N_W-1:0]   LAST_SIN = N_W'(2 * TERM_COUNT - 1);
   localparam logic [N_W-1:0]   LAST_COS = N_W'(2 * TERM_COUNT - 2);
   localparam logic [N_W-1:0]   LAST_EXP = N_W'(TERM_COUNT - 1);
   localparam logic [RES_W-1:0] ONE      = RES_W'(64'd1 << FRAC_BITS);

   state_type          state_ff, state_in;
   logic [N_W-1:0]     n_ff;
   logic [N_W-1:0]     last_ff;
   logic [1:0]         func_ff;
   logic               x_neg_ff;
   logic [X_W-1:0]     ax_ff;
   logic [MAG_W-1:0]   t_mag_ff;
   logic               t_neg_ff;
   logic [RES_W-1:0]   sum_ff;

   logic [X_W-1:0]     x_bits;
   logic [X_W-1:0]     x_abs;
   logic               accept;

   mul_ctrl_type       mul_ctrl;
   logic [HALF_W-1:0]  mul_a;
   logic [PROD_W-1:0]  acc;

   logic               div_start;
   logic               div_done;
   logic [MAG_W-1:0]   div_quotient;
   logic [MAG_W-1:0]   div_dividend;

   logic               use_term;
   logic               minus_term;
   logic               term_sub;
   logic               term_neg;
   logic [SUMX_W-1:0]  add_ext;
   logic [SUMX_W-1:0]  sum_ext;
   logic [SUMX_W-1:0]  sum_raw;
   logic [RES_W-1:0]   sum_sat;

   logic [WIDE_W-1:0]  prod_wide;
   logic [QUO_W-1:0]   q_raw;
   logic [QUO_W-1:0]   q_inc;
   logic [QUO_W-1:0]   q_sat;
   logic               big;
   logic               rem_bits;

   assign x_bits = req_x_value;
   assign x_abs  = x_bits[X_W-1] ? ((~x_bits) + X_W'(1)) : x_bits;
   assign accept = start && !busy;

   // which terms enter the sum, and with which sign
   always_comb begin
      use_term   = 1'b0;
      minus_term = 1'b0;
      unique case (func_ff)
         FUNC_SIN: begin
            use_term   = n_ff[0];
            minus_term = (n_ff[1:0] == 2'b11);
         end
         FUNC_COS: begin
            use_term   = !n_ff[0];
            minus_term = (n_ff[1:0] == 2'b10);
         end
         FUNC_EXP: begin
            use_term   = 1'b1;
         end
         default: begin
            use_term   = 1'b0;
         end
      endcase
   end

   // saturating accumulate into the 48-bit sum
   assign term_sub = t_neg_ff ^ minus_term;
   assign add_ext  = {2'b00, t_mag_ff};
   assign sum_ext  = {{(SUMX_W-RES_W){sum_ff[RES_W-1]}}, sum_ff};
   assign sum_raw  = term_sub ? (sum_ext - add_ext) : (sum_ext + add_ext);

   always_comb begin
      if ((&sum_raw[SUMX_W-1:RES_W-1]) || !(|sum_raw[SUMX_W-1:RES_W-1])) begin
         sum_sat = sum_raw[RES_W-1:0];
      end else if (sum_raw[SUMX_W-1]) begin
         sum_sat = {1'b1, {(RES_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(RES_W-1){1'b1}}};
      end
   end

   // product scaling: floor shift on the signed value, then magnitude clamp
   assign term_neg  = t_neg_ff ^ x_neg_ff;
   assign prod_wide = WIDE_W'(acc);
   assign q_raw     = prod_wide[FRAC_BITS +: QUO_W];
   assign big       = |(prod_wide >> (QUO_W + FRAC_BITS));
   assign rem_bits  = |(acc & ((PROD_W'(1) << FRAC_BITS) - PROD_W'(1)));
   assign q_inc     = q_raw + QUO_W'(term_neg && rem_bits && !big);
   assign q_sat     = (big || (q_inc > MAG_LIMIT)) ? MAG_LIMIT : q_inc;
   assign div_dividend = q_sat[MAG_W-1:0];

   assign mul_a = (state_ff == ST_MUL_LO) ? t_mag_ff[HALF_W-1:0]
                                          : {1'b0, t_mag_ff[MAG_W-1:HALF_W]};

   tsce_mul_acc u_mul (
      .clock (clock),
      .ctrl  (mul_ctrl),
      .mul_a (mul_a),
      .mul_b (ax_ff),
      .acc   (acc)
   );

   tsce_div_unit #(
      .N_W (N_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_func == FUNC_NONE) ? ST_DONE : ST_ACCUM;
            end
         end
         ST_ACCUM:   state_in = (n_ff == last_ff) ? ST_DONE : ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_MUL_SUM;
         ST_MUL_SUM: state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      mul_ctrl  = '0;
      unique case (state_ff)
         ST_IDLE:    busy = 1'b0;
         ST_MUL_LO:  mul_ctrl.mul_en = 1'b1;
         ST_MUL_HI: begin
            mul_ctrl.mul_en   = 1'b1;
            mul_ctrl.acc_load = 1'b1;
         end
         ST_MUL_SUM: mul_ctrl.acc_add = 1'b1;
         ST_SCALE:   div_start = 1'b1;
         ST_DONE:    rsp_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

   assign rsp_result_value = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         x_neg_ff <= x_bits[X_W-1];
         ax_ff    <= x_abs;
         t_mag_ff <= MAG_W'(x_abs);
         t_neg_ff <= x_bits[X_W-1];
         n_ff     <= N_W'(1);
         case (req_func)
            FUNC_SIN: last_ff <= LAST_SIN;
            FUNC_COS: last_ff <= LAST_COS;
            default:  last_ff <= LAST_EXP;
         endcase
         sum_ff <= (req_func == FUNC_COS || req_func == FUNC_EXP) ? ONE : '0;
      end else if (state_ff == ST_ACCUM) begin
         if (use_term) begin
            sum_ff <= sum_sat;
         end
         n_ff <= N_W'(n_ff + 1'b1);
      end else if (state_ff == ST_DIVIDE && div_done) begin
         t_mag_ff <= div_quotient;
         t_neg_ff <= term_neg && (div_quotient != '0);
      end
   end

   `TSCE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy missing after accept")
   `TSCE_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   `TSCE_ASSERT_SAME(a_div_in_step, clock, reset, div_done, state_ff == ST_DIVIDE, "stray divider done")
   `TSCE_ASSERT_NEXT(a_unused_zero, clock, reset, start && !busy && req_func == FUNC_NONE, rsp_valid && rsp_result_value == '0, "unused func must give zero")

endmodule

// File: sim/taylor_sin_cos_exp_unit_checker.sv
// Scoreboard for the sin/cos/exp series unit: predicts each sum and checks the result beats.
module taylor_sin_cos_exp_unit_checker #(
   parameter int TERM_COUNT = 21,
   parameter int FRAC_BITS  = 28
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_func,
   input  logic signed [tsce_pkg::X_W-1:0]    req_x_value,
   input  logic                               rsp_valid,
   input  logic signed [tsce_pkg::RES_W-1:0]  rsp_result_value,
   output int                                 fail_count,
   output int                                 pending_count
);
   import tsce_pkg::*;

   localparam logic signed [63:0] SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;

   logic signed [RES_W-1:0] sum_queue [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // t(n) = floor(t(n-1) * x / 2^FRAC_BITS) / n, quotient truncated toward zero
   function automatic logic signed [63:0] next_power_term(input logic signed [63:0] term,
                                                          input logic signed [63:0] arg,
                                                          input int unsigned n);
      logic         neg;
      logic [63:0]  at;
      logic [63:0]  ax;
      logic [127:0] prod;
      logic [63:0]  q;
      logic         rem;
      logic         big;
      neg  = (term < 0) != (arg < 0);
      at   = (term < 0) ? -term : term;
      ax   = (arg < 0) ? -arg : arg;
      prod = {64'd0, at} * {64'd0, ax};
      rem  = |prod[FRAC_BITS-1:0];
      big  = |prod[127:FRAC_BITS+64];
      q    = prod[FRAC_BITS+63 -: 64];
      // magnitude rounding up on a negative product gives the floor shift
      if (neg && rem && !big)
         q = q + 64'd1;
      if (big || q > MAG_LIMIT)
         q = MAG_LIMIT;
      q = q / 64'(n);
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [RES_W-1:0] series_sum(input logic [1:0] func,
                                                          input logic signed [X_W-1:0] x_in);
      logic signed [63:0] arg;
      logic signed [63:0] term;
      logic signed [63:0] sum;
      int unsigned        last;
      logic               take;
      logic               minus;
      arg  = x_in;
      term = arg;
      sum  = 64'sd0;
      case (func)
         FUNC_SIN: last = 2 * TERM_COUNT - 1;
         FUNC_COS: begin
            last = 2 * TERM_COUNT - 2;
            sum  = 64'sd1 <<< FRAC_BITS;
         end
         FUNC_EXP: begin
            last = TERM_COUNT - 1;
            sum  = 64'sd1 <<< FRAC_BITS;
         end
         default: return '0;
      endcase
      for (int unsigned n = 1; n <= last; n++) begin
         if (n > 1)
            term = next_power_term(term, arg, n);
         minus = 1'b0;
         case (func)
            FUNC_SIN: begin
               take  = n[0];
               minus = (n[1:0] == 2'd3);
            end
            FUNC_COS: begin
               take  = !n[0];
               minus = (n[1:0] == 2'd2);
            end
            default: take = 1'b1;
         endcase
         if (take) begin
            sum = sum + (minus ? -term : term);
            if (sum > SUM_HI)
               sum = SUM_HI;
            if (sum < SUM_LO)
               sum = SUM_LO;
         end
      end
      return sum[RES_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic signed [RES_W-1:0] want;
      if (!reset) begin
         if (rsp_valid) begin
            if (sum_queue.size() == 0) begin
               $error("result_value: expected none, actual %0d", rsp_result_value);
               fail_count <= fail_count + 1;
            end else begin
               want = sum_queue.pop_front();
               if (rsp_result_value !== want) begin
                  $error("result_value: expected %0d, actual %0d", want, rsp_result_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            sum_queue.push_back(series_sum(req_func, req_x_value));
      end
      pending_count <= sum_queue.size();
   end

endmodule

// File: sim/tb_taylor_sin_cos_exp_unit_top.sv
// Testbench top for the sin/cos/exp series unit: clock, reset, stimulus and verdict.
module tb_taylor_sin_cos_exp_unit_top;
   import tsce_pkg::*;

   localparam int TERMS          = 21;
   localparam int FRAC           = 28;
   localparam int RANDOM_ITEMS   = 750;
   localparam int STEADY_ITEMS   = 100;   // tail of the run with no sender gaps
   localparam int WATCHDOG_LIMIT = 5000;  // above the slowest item plus a sender gap

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_func = FUNC_SIN;
   logic signed [X_W-1:0]    req_x_value = '0;
   logic                     rsp_valid;
   logic signed [RES_W-1:0]  rsp_result_value;
   int                       fail_count;
   int                       pending_count;
   int                       idle_cycles = 0;

   taylor_sin_cos_exp_unit_top #(
      .TERM_COUNT (TERMS),
      .FRAC_BITS  (FRAC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_x_value      (req_x_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value)
   );

   taylor_sin_cos_exp_unit_checker #(
      .TERM_COUNT (TERMS),
      .FRAC_BITS  (FRAC)
   ) scoreboard (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_x_value      (req_x_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // busy read right after the edge is its value at the edge
   task automatic issue_arg(input logic [1:0] func, input logic signed [X_W-1:0] arg,
                            input bit allow_gap);
      int gap;
      start       <= 1'b1;
      req_func    <= func;
      req_x_value <= arg;
      do @(posedge clock); while (busy);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [X_W-1:0] random_arg();
      logic signed [X_W-1:0] arg;
      arg = $urandom();
      case ($urandom_range(0, 3))
         0: arg = arg >>> $urandom_range(1, 31);
         1: arg = arg[31] ? 32'sh8000_0000 + $urandom_range(0, 255)
                          : 32'sh7FFF_FFFF - $urandom_range(0, 255);
         2: arg = arg >>> $urandom_range(2, 6);  // moderate magnitudes
         default: ;
      endcase
      return arg;
   endfunction

   initial begin
      logic signed [X_W-1:0] corner_args [7] = '{
         32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001,
         32'shFFFF_FFFF, 32'sh1000_0000, 32'shF000_0000
      };
      logic [1:0] func;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // corners of the argument for each function, then the unused selector
      foreach (corner_args[k]) begin
         issue_arg(FUNC_SIN, corner_args[k], 1'b1);
         issue_arg(FUNC_COS, corner_args[k], 1'b1);
         issue_arg(FUNC_EXP, corner_args[k], 1'b1);
      end
      issue_arg(FUNC_NONE, 32'shFFFF_FFFF, 1'b1);
      issue_arg(FUNC_NONE, 32'sh0000_0000, 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 15))
            0:       func = FUNC_NONE;
            1, 2, 3, 4, 5: func = FUNC_SIN;
            6, 7, 8, 9, 10: func = FUNC_COS;
            default: func = FUNC_EXP;
         endcase
         issue_arg(func, random_arg(), i < RANDOM_ITEMS - STEADY_ITEMS);
      end
      start <= 1'b0;

      // pending count is a registered copy of the queue size
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/tsce_pkg.sv
rtl/tsce_mul_acc.sv
rtl/tsce_div_unit.sv
rtl/taylor_sin_cos_exp_unit_top.sv
sim/taylor_sin_cos_exp_unit_checker.sv
sim/tb_taylor_sin_cos_exp_unit_top.sv
